>>> rtl/pfba_pkg.sv
// Package for the page frame bitmap allocator.
// Holds the request/response payload types, the chain token and write command
// types, and the fixed widths and codes. It depends on nothing else.
package pfba_pkg;

  // Fixed widths of the request and response fields.
  localparam int START_W = 10;
  localparam int COUNT_W = 11;
  localparam int FOUND_W = 10;

  // Frames held by one cell of the chain, and log2 of that.
  localparam int CELL_W   = 32;
  localparam int LOG_CELL = 5;

  // Frame index width for the largest pool (65536 frames), and a bound width
  // that also holds the pool size itself and start + count of a request.
  localparam int FIX_W = 16;
  localparam int BND_W = 17;

  // Request action codes.
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_RESERVE = 2'd2;

  // Register index taken from the word address of the configuration port.
  localparam logic REG_ENABLE = 1'b0;

  typedef struct packed {
    logic [1:0]         action;
    logic [START_W-1:0] start_frame;
    logic [COUNT_W-1:0] frame_count;
  } pfba_req_t;

  typedef struct packed {
    logic               ok;
    logic [FOUND_W-1:0] found_frame;
  } pfba_rsp_t;

  // Scan token handed from cell to cell. run is the number of free frames
  // that end just below the receiving cell, saturated at the count maximum.
  typedef struct packed {
    logic               vld;
    logic               done;
    logic [COUNT_W-1:0] run;
    logic [FIX_W-1:0]   pos;
  } pfba_tok_t;

  // Range write command broadcast to every cell: frames in [lo, hi) take fill.
  typedef struct packed {
    logic             en;
    logic             fill;
    logic [BND_W-1:0] lo;
    logic [BND_W-1:0] hi;
  } pfba_wr_t;

endpackage

>>> rtl/pfba_cell.sv
// One cell of the allocator chain: 32 free bits of the frame map.
// Depends on pfba_pkg for the token and write command types and widths.
module pfba_cell
  import pfba_pkg::*;
#(
  parameter int BASE  = 0,
  parameter int NBITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] scan_cnt,
  input  pfba_tok_t          tok_in,
  input  pfba_wr_t           wr,
  output pfba_tok_t          tok_out
);

  // Bits past the end of the pool are held at zero (used).
  localparam logic [CELL_W-1:0] VMASK = {CELL_W{1'b1}} >> (CELL_W - NBITS);
  localparam int RUN_W = COUNT_W + 1;
  localparam logic [COUNT_W-1:0] RUN_MAX = {COUNT_W{1'b1}};

  logic [CELL_W-1:0] word_r, word_nxt;
  pfba_tok_t         tok_r, tok_nxt;

  logic                hs [0:LOG_CELL][CELL_W];
  logic [LOG_CELL-1:0] ix [0:LOG_CELL][CELL_W];
  logic [RUN_W-1:0]    run_j [CELL_W];
  logic [CELL_W-1:0]   hit;
  logic                any_hit;
  logic [LOG_CELL-1:0] sel;
  logic [RUN_W-1:0]    run_top;
  logic [BND_W-1:0]    pos_full;
  logic [BND_W-1:0]    fidx;

  // Nearest used frame at or below each bit, by a five-level prefix.
  always_comb begin
    for (int j = 0; j < CELL_W; j++) begin
      hs[0][j] = ~word_r[j];
      ix[0][j] = LOG_CELL'(j);
    end
    for (int k = 0; k < LOG_CELL; k++) begin
      for (int j = 0; j < CELL_W; j++) begin
        if (j >= (1 << k) && !hs[k][j]) begin
          hs[k+1][j] = hs[k][j - (1 << k)];
          ix[k+1][j] = ix[k][j - (1 << k)];
        end else begin
          hs[k+1][j] = hs[k][j];
          ix[k+1][j] = ix[k][j];
        end
      end
    end
  end

  // Free run ending at each bit and the lowest bit where it reaches the count.
  always_comb begin
    any_hit = 1'b0;
    sel     = '0;
    for (int j = 0; j < CELL_W; j++) begin
      if (hs[LOG_CELL][j]) begin
        run_j[j] = RUN_W'(LOG_CELL'(j) - ix[LOG_CELL][j]);
      end else begin
        run_j[j] = RUN_W'(tok_in.run) + RUN_W'(j + 1);
      end
      hit[j] = tok_in.vld && !tok_in.done && VMASK[j] && (run_j[j] >= RUN_W'(scan_cnt));
    end
    for (int j = CELL_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        any_hit = 1'b1;
        sel     = LOG_CELL'(j);
      end
    end
    run_top  = run_j[CELL_W-1];
    pos_full = BND_W'(BASE) + BND_W'(sel) + BND_W'(1) - BND_W'(scan_cnt);
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.done) begin
      if (any_hit) begin
        tok_nxt.done = 1'b1;
        tok_nxt.pos  = pos_full[FIX_W-1:0];
      end else if (run_top > RUN_W'(RUN_MAX)) begin
        tok_nxt.run = RUN_MAX;
      end else begin
        tok_nxt.run = run_top[COUNT_W-1:0];
      end
    end
  end

  // Range write: each frame compares its own fixed index against the bounds.
  always_comb begin
    word_nxt = word_r;
    fidx     = '0;
    if (wr.en) begin
      for (int j = 0; j < CELL_W; j++) begin
        fidx = BND_W'(BASE + j);
        if (VMASK[j] && fidx >= wr.lo && fidx < wr.hi) begin
          word_nxt[j] = wr.fill;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= VMASK;
      tok_r  <= '0;
    end else begin
      word_r <= word_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator.
// Depends on pfba_pkg and instantiates a chain of pfba_cell cells.
//
// The free map of NUM_FRAMES page frames (1 = free) is spread over a chain of
// cells of 32 frames each, and resets to every frame free. An allocate request
// sends a scan token into the first cell; the token moves one cell per clock,
// carrying the length of the free run seen so far, and the first cell that
// completes a run of frame_count free frames marks the token done with the
// run's start. The token always reaches the end of the chain, so the scan
// across the whole chain sets the time an allocate takes from acceptance to
// result. The found run is then written used by a single range write seen by
// all cells. Free and reserve requests need only that range write, and a
// rejected request (enable clear, zero count, unknown action, allocate larger
// than the pool, range past the pool end) leaves the map as it was. One
// request is worked on at a time; the result sits in an output register, so a
// new request is taken while a finished result waits to be read. found_frame
// is the low 10 bits of the run start, and zero on failure and for free and
// reserve. The enable register lies at byte address 0 of the APB port; the
// user must see that it is written only while the block is idle, as the block
// itself does not enforce this.
module page_frame_bitmap_allocator
  import pfba_pkg::*;
#(
  parameter int NUM_FRAMES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  pfba_req_t   in_req,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output pfba_rsp_t   out_rsp,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NUM_WORDS = (NUM_FRAMES + CELL_W - 1) / CELL_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic               enable_r, enable_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  pfba_tok_t          lnch_r, lnch_nxt;
  logic               fill_r, fill_nxt;
  logic [BND_W-1:0]   lo_r, lo_nxt;
  logic [BND_W-1:0]   hi_r, hi_nxt;
  pfba_rsp_t          rsp_r, rsp_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfba_rsp_t          out_rsp_r, out_rsp_nxt;

  pfba_tok_t          tok [0:NUM_WORDS];
  pfba_wr_t           wr;
  pfba_tok_t          tok_end;
  logic               accept;
  logic               req_live;
  logic [BND_W-1:0]   range_end;

  // The chain: each cell holds up to 32 frames and passes the scan token onward.
  assign tok[0] = lnch_r;

  for (genvar c = 0; c < NUM_WORDS; c++) begin : g_cell
    localparam int REM   = NUM_FRAMES - c * CELL_W;
    localparam int NBITS = (REM > CELL_W) ? CELL_W : REM;
    pfba_cell #(
      .BASE  (c * CELL_W),
      .NBITS (NBITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .scan_cnt (cnt_r),
      .tok_in   (tok[c]),
      .wr       (wr),
      .tok_out  (tok[c+1])
    );
  end

  assign tok_end = tok[NUM_WORDS];

  // The range write is issued for one cycle while in the write state.
  assign wr.en   = (state_r == ST_WRITE);
  assign wr.fill = fill_r;
  assign wr.lo   = lo_r;
  assign wr.hi   = hi_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign req_live  = enable_r && (in_req.frame_count != '0);
  assign range_end = BND_W'(in_req.start_frame) + BND_W'(in_req.frame_count);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lnch_nxt      = '0;
    fill_nxt      = fill_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Failure is the default; the legal cases below override it.
          rsp_nxt   = '0;
          state_nxt = ST_RESP;
          cnt_nxt   = in_req.frame_count;
          case (in_req.action) inside
            ACT_ALLOC: begin
              if (req_live && BND_W'(in_req.frame_count) <= BND_W'(NUM_FRAMES)) begin
                lnch_nxt.vld = 1'b1;
                state_nxt    = ST_SCAN;
              end
            end
            ACT_FREE, ACT_RESERVE: begin
              if (req_live && range_end <= BND_W'(NUM_FRAMES)) begin
                fill_nxt   = (in_req.action == ACT_FREE);
                lo_nxt     = BND_W'(in_req.start_frame);
                hi_nxt     = range_end;
                rsp_nxt.ok = 1'b1;
                state_nxt  = ST_WRITE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The token leaves the last cell after passing through every cell of the chain.
        if (tok_end.vld) begin
          if (tok_end.done) begin
            fill_nxt            = 1'b0;
            lo_nxt              = BND_W'(tok_end.pos);
            hi_nxt              = BND_W'(tok_end.pos) + BND_W'(cnt_r);
            rsp_nxt.ok          = 1'b1;
            rsp_nxt.found_frame = tok_end.pos[FOUND_W-1:0];
            state_nxt           = ST_WRITE;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_WRITE: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // Load the output register once it is empty or being read.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = rsp_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration: a write lands on the access cycle of the APB transfer.
  always_comb begin
    enable_nxt = enable_r;
    if (psel && penable && pwrite && pready && paddr[2] == REG_ENABLE) begin
      enable_nxt = pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      lnch_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      lnch_r      <= lnch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    fill_r    <= fill_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    rsp_r     <= rsp_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
